// ----- hdl/ldcfs_pkg.sv -----
// Shared types and constants for the LED driver chain frame sender.
package ldcfs_pkg;

   localparam int unsigned CHANNELS_PER_CHIP = 16;
   localparam int unsigned ROW_W = 4;
   localparam int unsigned WORD_W = 16;
   localparam int unsigned GAIN_W = 6;
   localparam int unsigned OP_W = 3;
   localparam int unsigned INDEX_W = 8;
   localparam int unsigned LATCH_W = 4;

   // Command codes
   localparam logic [OP_W-1:0] OP_SET_CHANNEL = 3'd0;
   localparam logic [OP_W-1:0] OP_SEND_ROW = 3'd1;
   localparam logic [OP_W-1:0] OP_SEND_CONFIG = 3'd2;
   localparam logic [OP_W-1:0] OP_ALL_ON = 3'd3;
   localparam logic [OP_W-1:0] OP_ALL_OFF = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

   // Latch enable counts on the final bits of a word
   localparam logic [LATCH_W-1:0] LATCH_NONE = 4'd0;
   localparam logic [LATCH_W-1:0] LATCH_SWITCH = 4'd2;
   localparam logic [LATCH_W-1:0] LATCH_DATA = 4'd4;
   localparam logic [LATCH_W-1:0] LATCH_GLOBAL = 4'd6;
   localparam logic [LATCH_W-1:0] LATCH_CONFIG = 4'd7;

   localparam logic [ROW_W-1:0] LAST_ROW = 4'd15;
   localparam logic [WORD_W-1:0] WORD_ALL_ON = 16'hffff;
   localparam logic [WORD_W-1:0] WORD_ALL_OFF = 16'h0000;

   // Controller to datapath commands
   typedef struct packed {
      logic mem_write;
      logic write_zero;
      logic mem_read;
      logic load_word;
      logic emit;
      logic emit_last;
   } ldcfs_cmd_type;

endpackage

// ----- hdl/led_driver_chain_frame_sender.sv -----
// Top level of the LED driver chain frame sender.
//
// Commands are taken on start while busy is low. Set channel and unused codes
// finish at once. Send row, send config, all on and all off each give
// CHIP_COUNT words, one per clock cycle, chip 0 first; the first word appears
// once the emit state has read it into the result registers, and busy drops
// on the cycle the last word appears. The pace is set by the single read port
// of the brightness store, one chip per cycle. Clear runs a sweep that zeroes
// the store one word per cycle with busy high; the same sweep runs right after
// reset. Each result beat is on rsp_* for exactly one cycle with rsp_valid
// high: the receiver cannot stall it. The gain register is written through
// csr_valid, which is always ready.
module led_driver_chain_frame_sender #(
   parameter int unsigned CHIP_COUNT = 9
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [ldcfs_pkg::OP_W-1:0]         req_operation,
   input  logic [ldcfs_pkg::INDEX_W-1:0]      req_led_index,
   input  logic [ldcfs_pkg::WORD_W-1:0]       req_value,
   input  logic [ldcfs_pkg::ROW_W-1:0]        req_row,
   output logic                               rsp_valid,
   output logic [ldcfs_pkg::WORD_W-1:0]       rsp_data_word,
   output logic [ldcfs_pkg::LATCH_W-1:0]      rsp_latch_clocks,
   output logic                               rsp_last,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ldcfs_pkg::GAIN_W-1:0]       csr_wdata
);

   localparam int unsigned DEPTH = ldcfs_pkg::CHANNELS_PER_CHIP * CHIP_COUNT;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam int unsigned CHIP_W = (CHIP_COUNT > 1) ? $clog2(CHIP_COUNT) : 1;

   ldcfs_pkg::ldcfs_cmd_type cmd;
   logic [ADDR_W-1:0]        mem_addr;

   assign csr_ready = 1'b1;

   ldcfs_ctrl #(
      .CHIP_COUNT(CHIP_COUNT),
      .DEPTH(DEPTH),
      .ADDR_W(ADDR_W),
      .CHIP_W(CHIP_W)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_operation(req_operation),
      .req_led_index(req_led_index),
      .req_row(req_row),
      .cmd(cmd),
      .mem_addr(mem_addr)
   );

   ldcfs_datapath #(
      .DEPTH(DEPTH),
      .ADDR_W(ADDR_W)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .mem_addr(mem_addr),
      .req_operation(req_operation),
      .req_row(req_row),
      .req_value(req_value),
      .csr_valid(csr_valid),
      .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid),
      .rsp_data_word(rsp_data_word),
      .rsp_latch_clocks(rsp_latch_clocks),
      .rsp_last(rsp_last)
   );

endmodule

// ----- hdl/ldcfs_ctrl.sv -----
// Controller: command decode, store clearing sweep and per-chip word sequencing.
module ldcfs_ctrl #(
   parameter int unsigned CHIP_COUNT = 9,
   parameter int unsigned DEPTH = 144,
   parameter int unsigned ADDR_W = 8,
   parameter int unsigned CHIP_W = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [ldcfs_pkg::OP_W-1:0]         req_operation,
   input  logic [ldcfs_pkg::INDEX_W-1:0]      req_led_index,
   input  logic [ldcfs_pkg::ROW_W-1:0]        req_row,
   output ldcfs_pkg::ldcfs_cmd_type           cmd,
   output logic [ADDR_W-1:0]                  mem_addr
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CLEAR = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   localparam int unsigned IDX_W = (ADDR_W > ldcfs_pkg::INDEX_W) ? ADDR_W : ldcfs_pkg::INDEX_W;
   localparam int unsigned RD_W = CHIP_W + ldcfs_pkg::ROW_W;
   localparam logic [CHIP_W-1:0] LAST_CHIP = CHIP_W'(CHIP_COUNT - 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   logic [1:0]                      state_ff, state_in;
   logic [CHIP_W-1:0]               chip_ff, chip_in;
   logic [ADDR_W-1:0]               clr_addr_ff, clr_addr_in;
   logic [ldcfs_pkg::ROW_W-1:0]     row_ff, row_in;
   logic                            accept;
   logic [IDX_W-1:0]                led_ext;
   logic [RD_W-1:0]                 rd_full;
   logic                            in_range;

   assign busy = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign led_ext = IDX_W'(req_led_index);
   assign rd_full = {chip_ff, row_ff};
   assign in_range = (32'(req_led_index) < 32'(DEPTH));

   always_comb begin
      state_in = state_ff;
      chip_in = chip_ff;
      clr_addr_in = clr_addr_ff;
      row_in = row_ff;
      cmd = '0;
      mem_addr = led_ext[ADDR_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_operation)
                  ldcfs_pkg::OP_SET_CHANNEL: begin
                     cmd.mem_write = in_range;
                  end
                  ldcfs_pkg::OP_SEND_ROW, ldcfs_pkg::OP_SEND_CONFIG,
                  ldcfs_pkg::OP_ALL_ON, ldcfs_pkg::OP_ALL_OFF: begin
                     cmd.load_word = 1'b1;
                     state_in = ST_EMIT;
                     chip_in = '0;
                     row_in = req_row;
                  end
                  ldcfs_pkg::OP_CLEAR: begin
                     state_in = ST_CLEAR;
                     clr_addr_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            cmd.mem_write = 1'b1;
            cmd.write_zero = 1'b1;
            mem_addr = clr_addr_ff;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            cmd.mem_read = 1'b1;
            cmd.emit = 1'b1;
            mem_addr = rd_full[ADDR_W-1:0];
            if (chip_ff == LAST_CHIP) begin
               cmd.emit_last = 1'b1;
               state_in = ST_IDLE;
            end else begin
               chip_in = chip_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // sweep the store to zero after reset
         state_ff <= ST_CLEAR;
         clr_addr_ff <= '0;
         chip_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_addr_ff <= clr_addr_in;
         chip_ff <= chip_in;
      end
      row_ff <= row_in;
   end

endmodule

// ----- hdl/ldcfs_datapath.sv -----
// Datapath: brightness store, gain register, word select and result registers.
module ldcfs_datapath #(
   parameter int unsigned DEPTH = 144,
   parameter int unsigned ADDR_W = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ldcfs_pkg::ldcfs_cmd_type           cmd,
   input  logic [ADDR_W-1:0]                  mem_addr,
   input  logic [ldcfs_pkg::OP_W-1:0]         req_operation,
   input  logic [ldcfs_pkg::ROW_W-1:0]        req_row,
   input  logic [ldcfs_pkg::WORD_W-1:0]       req_value,
   input  logic                               csr_valid,
   input  logic [ldcfs_pkg::GAIN_W-1:0]       csr_wdata,
   output logic                               rsp_valid,
   output logic [ldcfs_pkg::WORD_W-1:0]       rsp_data_word,
   output logic [ldcfs_pkg::LATCH_W-1:0]      rsp_latch_clocks,
   output logic                               rsp_last
);

   logic [ldcfs_pkg::WORD_W-1:0]  store_mem [0:DEPTH-1];
   logic [ldcfs_pkg::WORD_W-1:0]  rd_data_ff;
   logic [ldcfs_pkg::WORD_W-1:0]  word_ff, word_in;
   logic [ldcfs_pkg::LATCH_W-1:0] final_latch_ff, final_latch_in;
   logic                          sel_mem_ff;
   logic [ldcfs_pkg::GAIN_W-1:0]  gain_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_last_ff;
   logic [ldcfs_pkg::LATCH_W-1:0] rsp_latch_ff;
   logic [ldcfs_pkg::WORD_W-1:0]  wdata;

   assign wdata = cmd.write_zero ? ldcfs_pkg::WORD_ALL_OFF : req_value;

   always_comb begin
      word_in = ldcfs_pkg::WORD_ALL_OFF;
      final_latch_in = ldcfs_pkg::LATCH_SWITCH;
      unique case (req_operation)
         ldcfs_pkg::OP_SEND_ROW: begin
            final_latch_in = (req_row == ldcfs_pkg::LAST_ROW) ?
                             ldcfs_pkg::LATCH_GLOBAL : ldcfs_pkg::LATCH_DATA;
         end
         ldcfs_pkg::OP_SEND_CONFIG: begin
            word_in = ldcfs_pkg::WORD_W'(gain_ff);
            final_latch_in = ldcfs_pkg::LATCH_CONFIG;
         end
         ldcfs_pkg::OP_ALL_ON: begin
            word_in = ldcfs_pkg::WORD_ALL_ON;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_write) begin
         store_mem[mem_addr] <= wdata;
      end
      if (cmd.mem_read) begin
         rd_data_ff <= store_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            gain_ff <= csr_wdata;
         end
         rsp_valid_ff <= cmd.emit;
      end
      if (cmd.load_word) begin
         word_ff <= word_in;
         final_latch_ff <= final_latch_in;
         sel_mem_ff <= (req_operation == ldcfs_pkg::OP_SEND_ROW);
      end
      rsp_last_ff <= cmd.emit_last;
      rsp_latch_ff <= cmd.emit_last ? final_latch_ff : ldcfs_pkg::LATCH_NONE;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data_word = sel_mem_ff ? rd_data_ff : word_ff;
   assign rsp_latch_clocks = rsp_latch_ff;
   assign rsp_last = rsp_last_ff;

endmodule

// ----- test/frame_word_checker.sv -----
// Checker that predicts the chain words of the frame sender and compares every result beat.
`timescale 1ns / 100ps
module frame_word_checker #(
   parameter int unsigned CHIP_COUNT = 9
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic [ldcfs_pkg::OP_W-1:0]         req_operation,
   input  logic [ldcfs_pkg::INDEX_W-1:0]      req_led_index,
   input  logic [ldcfs_pkg::WORD_W-1:0]       req_value,
   input  logic [ldcfs_pkg::ROW_W-1:0]        req_row,
   input  logic                               rsp_valid,
   input  logic [ldcfs_pkg::WORD_W-1:0]       rsp_data_word,
   input  logic [ldcfs_pkg::LATCH_W-1:0]      rsp_latch_clocks,
   input  logic                               rsp_last,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [ldcfs_pkg::GAIN_W-1:0]       csr_wdata,
   output int                                 fail_count,
   output int                                 words_pending
);
   import ldcfs_pkg::*;

   localparam int unsigned STORE_DEPTH = CHANNELS_PER_CHIP * CHIP_COUNT;

   typedef struct packed {
      logic [WORD_W-1:0]  word;
      logic [LATCH_W-1:0] latch;
      logic               last;
   } chain_word_type;

   logic [WORD_W-1:0] shadow_brightness [STORE_DEPTH];
   logic [GAIN_W-1:0] shadow_gain;
   chain_word_type    expected_words [$];
   int                mismatches = 0;

   always @(posedge clock) begin
      chain_word_type    seen;
      chain_word_type    want;
      logic [WORD_W-1:0] run_word;
      logic [LATCH_W-1:0] run_latch;
      logic              emits_run;
      if (reset) begin
         foreach (shadow_brightness[i]) shadow_brightness[i] = '0;
         shadow_gain = '0;
         expected_words.delete();
      end else begin
         // Compare first: a beat on this edge always belongs to an earlier command.
         if (rsp_valid) begin
            seen = chain_word_type'{rsp_data_word, rsp_latch_clocks, rsp_last};
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected beat word=%h latch=%0d last=%b", $realtime,
                           rsp_data_word, rsp_latch_clocks, rsp_last);
            end else begin
               want = expected_words.pop_front();
               if (seen !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch: expected word=%h latch=%0d last=%b, %s%h %s%0d %s%b",
                              $realtime, want.word, want.latch, want.last,
                              "got word=", seen.word, "latch=", seen.latch, "last=", seen.last);
               end
            end
         end

         if (csr_valid && csr_ready) shadow_gain = csr_wdata;

         if (start && !busy) begin
            emits_run = 1'b1;
            run_word = '0;
            run_latch = LATCH_SWITCH;
            case (req_operation)
               OP_SET_CHANNEL: begin
                  emits_run = 1'b0;
                  if (req_led_index < STORE_DEPTH) shadow_brightness[req_led_index] = req_value;
               end
               OP_CLEAR: begin
                  emits_run = 1'b0;
                  foreach (shadow_brightness[i]) shadow_brightness[i] = '0;
               end
               OP_SEND_ROW: begin
                  run_latch = (req_row == LAST_ROW) ? LATCH_GLOBAL : LATCH_DATA;
               end
               OP_SEND_CONFIG: begin
                  run_word = WORD_W'(shadow_gain);
                  run_latch = LATCH_CONFIG;
               end
               OP_ALL_ON: begin
                  run_word = WORD_ALL_ON;
               end
               OP_ALL_OFF: begin
                  run_word = WORD_ALL_OFF;
               end
               default: begin
                  emits_run = 1'b0;
               end
            endcase
            // One word per chip, chip 0 first; only the final word latches.
            if (emits_run) begin
               for (int chip = 0; chip < CHIP_COUNT; chip++) begin
                  if (req_operation == OP_SEND_ROW)
                     run_word = shadow_brightness[req_row + CHANNELS_PER_CHIP * chip];
                  if (chip == CHIP_COUNT - 1)
                     expected_words.push_back(chain_word_type'{run_word, run_latch, 1'b1});
                  else
                     expected_words.push_back(chain_word_type'{run_word, LATCH_NONE, 1'b0});
               end
            end
         end
      end
      fail_count <= mismatches;
      words_pending <= expected_words.size();
   end

endmodule

// ----- test/testbench.sv -----
// Stimulus and verdict for the LED driver chain frame sender.
`timescale 1ns / 100ps
module testbench;
   import ldcfs_pkg::*;

   localparam int unsigned CHIP_COUNT = 9;
   localparam int unsigned STORE_DEPTH = CHANNELS_PER_CHIP * CHIP_COUNT;
   localparam int unsigned GAP_PERCENT = 12;
   localparam int unsigned PHASE_ITEMS = 62;
   localparam logic [OP_W-1:0] OP_UNUSED_LOW = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED_HIGH = 3'd7;
   localparam logic [INDEX_W-1:0] INDEX_MAX = {INDEX_W{1'b1}};

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [OP_W-1:0]     req_operation = '0;
   logic [INDEX_W-1:0]  req_led_index = '0;
   logic [WORD_W-1:0]   req_value = '0;
   logic [ROW_W-1:0]    req_row = '0;
   logic                rsp_valid;
   logic [WORD_W-1:0]   rsp_data_word;
   logic [LATCH_W-1:0]  rsp_latch_clocks;
   logic                rsp_last;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [GAIN_W-1:0]   csr_wdata = '0;
   int                  fail_count;
   int                  words_pending;
   bit                  gaps_on = 1'b1;

   always #5 clock = ~clock;

   led_driver_chain_frame_sender #(.CHIP_COUNT(CHIP_COUNT)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_led_index(req_led_index),
      .req_value(req_value), .req_row(req_row),
      .rsp_valid(rsp_valid), .rsp_data_word(rsp_data_word),
      .rsp_latch_clocks(rsp_latch_clocks), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   frame_word_checker #(.CHIP_COUNT(CHIP_COUNT)) word_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_led_index(req_led_index),
      .req_value(req_value), .req_row(req_row),
      .rsp_valid(rsp_valid), .rsp_data_word(rsp_data_word),
      .rsp_latch_clocks(rsp_latch_clocks), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .words_pending(words_pending)
   );

   initial begin
      #4_000_000;
      $display("simulation failed");
      $finish;
   end

   // Drive one command beat and hold it until the block takes it.
   task automatic issue_command(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                                input logic [WORD_W-1:0] val, input logic [ROW_W-1:0] row);
      @(negedge clock);
      while (gaps_on && $urandom_range(0, 99) < GAP_PERCENT) begin
         start <= 1'b0;
         req_operation <= OP_W'($urandom);
         req_led_index <= INDEX_W'($urandom);
         req_value <= WORD_W'($urandom);
         req_row <= ROW_W'($urandom);
         @(negedge clock);
      end
      start <= 1'b1;
      req_operation <= op;
      req_led_index <= idx;
      req_value <= val;
      req_row <= row;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Drop start and wait until the block is idle with nothing outstanding.
   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      repeat (4) @(posedge clock);
      while (words_pending != 0 || busy) @(posedge clock);
   endtask

   task automatic write_gain(input logic [GAIN_W-1:0] gain);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= gain;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      csr_wdata <= GAIN_W'($urandom);
   endtask

   task automatic run_random_phase(input int unsigned target);
      int unsigned        counted;
      int unsigned        pick;
      logic [OP_W-1:0]    op;
      logic [INDEX_W-1:0] idx;
      logic [WORD_W-1:0]  val;
      counted = 0;
      while (counted < target) begin
         pick = $urandom_range(0, 99);
         idx = INDEX_W'($urandom);
         val = WORD_W'($urandom);
         if (pick < 40) begin
            op = OP_SET_CHANNEL;
            if ($urandom_range(0, 9) == 0)
               idx = INDEX_W'($urandom_range(STORE_DEPTH, INDEX_MAX));
            else
               idx = INDEX_W'($urandom_range(0, STORE_DEPTH - 1));
            case ($urandom_range(0, 9))
               0: val = WORD_ALL_ON;
               1: val = WORD_ALL_OFF;
               default: ;
            endcase
         end else if (pick < 70) begin
            op = OP_SEND_ROW;
         end else if (pick < 78) begin
            op = OP_SEND_CONFIG;
         end else if (pick < 85) begin
            op = OP_ALL_ON;
         end else if (pick < 92) begin
            op = OP_ALL_OFF;
         end else if (pick < 95) begin
            op = OP_CLEAR;
         end else begin
            op = ($urandom_range(0, 1) == 1) ? OP_UNUSED_HIGH : OP_UNUSED_LOW;
         end
         issue_command(op, idx, val, ROW_W'($urandom));
         // Skip ignored beats in the count.
         if (op <= OP_CLEAR && !(op == OP_SET_CHANNEL && idx >= STORE_DEPTH)) counted++;
      end
   endtask

   initial begin
      logic [GAIN_W-1:0] phase_gain [6];
      phase_gain = '{6'd63, 6'd0, GAIN_W'($urandom), 6'd1, 6'd32, GAIN_W'($urandom)};

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: gain at reset, index edges, both latching rows, codes with no effect.
      issue_command(OP_SEND_CONFIG, INDEX_MAX, WORD_ALL_ON, LAST_ROW);
      issue_command(OP_SEND_ROW, '0, '0, '0);
      issue_command(OP_SET_CHANNEL, 8'd0, WORD_ALL_ON, LAST_ROW);
      issue_command(OP_SET_CHANNEL, 8'(STORE_DEPTH - 1), 16'h8000, '0);
      issue_command(OP_SET_CHANNEL, 8'(STORE_DEPTH), 16'h1234, '0);
      issue_command(OP_SET_CHANNEL, INDEX_MAX, 16'haaaa, '0);
      issue_command(OP_SET_CHANNEL, 8'd15, 16'h5555, '0);
      issue_command(OP_SET_CHANNEL, 8'd127, 16'h0001, '0);
      issue_command(OP_SET_CHANNEL, 8'd128, 16'h7fff, '0);
      issue_command(OP_SEND_ROW, INDEX_MAX, WORD_ALL_ON, '0);
      issue_command(OP_SEND_ROW, '0, '0, LAST_ROW);
      issue_command(OP_UNUSED_LOW, 8'd1, 16'h1111, 4'd1);
      issue_command(OP_UNUSED_HIGH, 8'd2, 16'h2222, 4'd2);
      issue_command(OP_SEND_ROW, '0, '0, LAST_ROW);
      issue_command(OP_ALL_ON, '0, '0, '0);
      issue_command(OP_ALL_OFF, INDEX_MAX, WORD_ALL_ON, LAST_ROW);
      issue_command(OP_CLEAR, INDEX_MAX, WORD_ALL_ON, LAST_ROW);
      issue_command(OP_SEND_ROW, '0, '0, LAST_ROW);
      issue_command(OP_SEND_ROW, '0, '0, '0);
      settle();
      write_gain(6'h2a);
      issue_command(OP_SEND_CONFIG, '0, '0, '0);

      for (int phase = 0; phase < 6; phase++) begin
         settle();
         write_gain(phase_gain[phase]);
         // Hold one phase with no gaps at all.
         gaps_on = (phase != 2);
         run_random_phase(PHASE_ITEMS);
      end

      settle();
      repeat (CHIP_COUNT + 4) @(posedge clock);
      if (fail_count == 0 && words_pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
